FILE: rtl/core/dea_pkg.sv
// Shared types, codes and constants of the double-ended arena allocator.
package dea_pkg;

    localparam int ADDR_BITS = 24;
    localparam int CNT_BITS  = 20;

    localparam logic [ADDR_BITS-1:0] ARENA_RESET = ADDR_BITS'(8912896);
    localparam logic [CNT_BITS-1:0]  CNT_MAX     = {CNT_BITS{1'b1}};

    localparam logic [ADDR_BITS:0] PERM_ROUND = (ADDR_BITS+1)'(31);
    localparam logic [ADDR_BITS:0] TEMP_ROUND = (ADDR_BITS+1)'(3);

    typedef enum logic [2:0] {
        OP_ALLOC_PERM = 3'd0,
        OP_ALLOC_TEMP = 3'd1,
        OP_FREE_TEMP  = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_SET_MODE   = 3'd4,
        OP_MARK       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_SOFT  = 2'd1,
        ST_FATAL = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]           op;
        logic [ADDR_BITS-1:0] request_bytes;
        logic                 fail_mode;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] block_offset;
        logic [ADDR_BITS-1:0] bottom_used;
        logic [ADDR_BITS-1:0] top_used;
        logic [ADDR_BITS-1:0] peak_used;
        logic [CNT_BITS-1:0]  alloc_total;
        logic [ADDR_BITS-1:0] since_mark;
    } t_rsp;

endpackage

FILE: rtl/core/dea_in_reg.sv
// Input register that holds one request word until the engine takes it.
module dea_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dea_pkg::t_req i_req,
    input  logic          i_take,
    output logic          o_stall,
    output logic          o_valid,
    output dea_pkg::t_req o_req
);

    logic          r_valid;
    dea_pkg::t_req r_req;
    logic          w_load;

    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_req <= i_req;
        end
    end

endmodule

FILE: rtl/core/dea_engine.sv
// Allocator state and the combinational request evaluation.
module dea_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  dea_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_cfg_data,
    output dea_pkg::t_rsp                 o_rsp
);

    localparam int AB = dea_pkg::ADDR_BITS;

    logic [AB-1:0]                r_arena;
    logic [AB-1:0]                r_bottom, n_bottom;
    logic [AB-1:0]                r_top, n_top;
    logic [AB-1:0]                r_peak, n_peak;
    logic [dea_pkg::CNT_BITS-1:0] r_count, n_count;
    logic [AB-1:0]                r_mark, n_mark;
    logic                         r_hard, n_hard;

    logic [AB:0]      w_rnd_perm, w_rnd_temp, w_rounded;
    logic [AB+1:0]    w_need;
    logic             w_fits;
    logic             w_alloc_ok;
    logic [AB:0]      w_sum_new;
    dea_pkg::t_status w_status;
    logic [AB-1:0]    w_offset;

    assign w_rnd_perm = ({1'b0, i_req.request_bytes} + dea_pkg::PERM_ROUND)
                        & ~dea_pkg::PERM_ROUND;
    assign w_rnd_temp = ({1'b0, i_req.request_bytes} + dea_pkg::TEMP_ROUND)
                        & ~dea_pkg::TEMP_ROUND;
    assign w_rounded  = (i_req.op == dea_pkg::OP_ALLOC_PERM) ? w_rnd_perm : w_rnd_temp;
    assign w_need     = {2'b00, r_bottom} + {2'b00, r_top} + {1'b0, w_rounded};
    assign w_fits     = w_need <= {2'b00, r_arena};

    always_comb begin
        n_bottom   = r_bottom;
        n_top      = r_top;
        n_count    = r_count;
        n_mark     = r_mark;
        n_hard     = r_hard;
        w_alloc_ok = 1'b0;
        w_status   = dea_pkg::ST_DONE;
        w_offset   = '0;
        case (i_req.op)
            dea_pkg::OP_ALLOC_PERM, dea_pkg::OP_ALLOC_TEMP: begin
                if (w_fits) begin
                    w_alloc_ok = 1'b1;
                    if (i_req.op == dea_pkg::OP_ALLOC_PERM) begin
                        n_bottom = r_bottom + w_rounded[AB-1:0];
                        w_offset = r_bottom;
                        if (r_count != dea_pkg::CNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_top    = r_top + w_rounded[AB-1:0];
                        w_offset = r_arena - n_top;
                    end
                end else begin
                    w_status = r_hard ? dea_pkg::ST_FATAL : dea_pkg::ST_SOFT;
                end
            end
            dea_pkg::OP_FREE_TEMP: begin
                n_top = '0;
            end
            dea_pkg::OP_CLEAR: begin
                n_hard   = 1'b1;
                n_count  = '0;
                n_bottom = '0;
                n_top    = '0;
            end
            dea_pkg::OP_SET_MODE: begin
                n_hard = i_req.fail_mode;
            end
            dea_pkg::OP_MARK: begin
                n_mark   = r_bottom;
                w_offset = r_bottom;
            end
            default: begin
            end
        endcase
    end

    assign w_sum_new = {1'b0, n_bottom} + {1'b0, n_top};

    always_comb begin
        if (i_req.op == dea_pkg::OP_CLEAR) begin
            n_peak = '0;
        end else if (w_alloc_ok && (w_sum_new > {1'b0, r_peak})) begin
            n_peak = w_sum_new[AB-1:0];
        end else begin
            n_peak = r_peak;
        end
    end

    assign o_rsp.status       = w_status;
    assign o_rsp.block_offset = w_offset;
    assign o_rsp.bottom_used  = n_bottom;
    assign o_rsp.top_used     = n_top;
    assign o_rsp.peak_used    = n_peak;
    assign o_rsp.alloc_total  = n_count;
    assign o_rsp.since_mark   = n_bottom - n_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena  <= dea_pkg::ARENA_RESET;
            r_bottom <= '0;
            r_top    <= '0;
            r_peak   <= '0;
            r_count  <= '0;
            r_mark   <= '0;
            r_hard   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_arena <= i_cfg_data;
            end
            if (i_fire) begin
                r_bottom <= n_bottom;
                r_top    <= n_top;
                r_peak   <= n_peak;
                r_count  <= n_count;
                r_mark   <= n_mark;
                r_hard   <= n_hard;
            end
        end
    end

    a_peak_covers_usage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_peak} >= ({1'b0, r_bottom} + {1'b0, r_top})))
        else $error("peak below current usage");

    a_refusal_keeps_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_rsp.status != dea_pkg::ST_DONE) |=>
            ($stable(r_bottom) && $stable(r_top) && $stable(r_count)))
        else $error("refused request changed levels");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.op == dea_pkg::OP_CLEAR) |=>
            (r_bottom == '0 && r_top == '0 && r_peak == '0 && r_hard))
        else $error("clear left state behind");

endmodule

FILE: rtl/core/dea_out_reg.sv
// Result register that holds one result word until the sink takes it.
module dea_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  dea_pkg::t_rsp i_rsp,
    input  logic          i_stall,
    output logic          o_free,
    output logic          o_valid,
    output dea_pkg::t_rsp o_rsp
);

    logic          r_valid;
    dea_pkg::t_rsp r_rsp;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

FILE: rtl/core/double_ended_arena_allocator_top.sv
// Top level of the double-ended arena allocator.
// Words pass from the input register through the engine into the result register.
// Throughput: one word per cycle while the sink does not stall; the update is one add,
// round and compare. Reset (synchronous, active low) empties the arena, zeroes all
// counters and the mark, sets hard-fail mode and loads the default arena size.
module double_ended_arena_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_op,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_request_bytes,
    input  logic                          i_fail_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [dea_pkg::ADDR_BITS-1:0] o_block_offset,
    output logic [dea_pkg::ADDR_BITS-1:0] o_bottom_used,
    output logic [dea_pkg::ADDR_BITS-1:0] o_top_used,
    output logic [dea_pkg::ADDR_BITS-1:0] o_peak_used,
    output logic [dea_pkg::CNT_BITS-1:0]  o_alloc_total,
    output logic [dea_pkg::ADDR_BITS-1:0] o_since_mark,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_cfg_data
);

    dea_pkg::t_req w_in_req, w_req;
    dea_pkg::t_rsp w_rsp, w_out_rsp;
    logic          w_req_valid;
    logic          w_out_free;
    logic          w_fire;

    assign w_in_req.op            = i_op;
    assign w_in_req.request_bytes = i_request_bytes;
    assign w_in_req.fail_mode     = i_fail_mode;

    assign w_fire      = w_req_valid && w_out_free;
    assign o_cfg_ready = 1'b1;

    dea_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_req   (w_in_req),
        .i_take  (w_fire),
        .o_stall (o_in_stall),
        .o_valid (w_req_valid),
        .o_req   (w_req)
    );

    dea_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_req      (w_req),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (w_rsp)
    );

    dea_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_rsp   (w_rsp),
        .i_stall (i_out_stall),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_rsp   (w_out_rsp)
    );

    assign o_status       = w_out_rsp.status;
    assign o_block_offset = w_out_rsp.block_offset;
    assign o_bottom_used  = w_out_rsp.bottom_used;
    assign o_top_used     = w_out_rsp.top_used;
    assign o_peak_used    = w_out_rsp.peak_used;
    assign o_alloc_total  = w_out_rsp.alloc_total;
    assign o_since_mark   = w_out_rsp.since_mark;

endmodule

FILE: bench/arena_checker.sv
// Checker for the arena allocator: predicts each response word and compares it on arrival.
module arena_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [2:0]                    i_op,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_request_bytes,
    input  logic                          i_fail_mode,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_status,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_block_offset,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_bottom_used,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_top_used,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_peak_used,
    input  logic [dea_pkg::CNT_BITS-1:0]  i_alloc_total,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_since_mark,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [dea_pkg::ADDR_BITS-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_outstanding,
    output int                            o_result_count,
    output int                            o_refusal_count
);
    import dea_pkg::*;

    logic [ADDR_BITS-1:0] arena_size;
    logic [ADDR_BITS-1:0] bottom_lvl;
    logic [ADDR_BITS-1:0] top_lvl;
    logic [ADDR_BITS-1:0] peak_lvl;
    logic [ADDR_BITS-1:0] mark_lvl;
    logic [CNT_BITS-1:0]  perm_count;
    logic                 fatal_mode;

    t_rsp predicted_rsp[$];

    function automatic t_rsp arena_step(input t_req req);
        t_rsp                 rsp;
        logic [ADDR_BITS:0]   rounded;
        logic [ADDR_BITS+2:0] need;
        logic [ADDR_BITS:0]   used;
        rsp = '0;
        rsp.status = ST_DONE;
        case (req.op)
            OP_ALLOC_PERM, OP_ALLOC_TEMP: begin
                if (req.op == OP_ALLOC_PERM) begin
                    rounded = ({1'b0, req.request_bytes} + PERM_ROUND) & ~PERM_ROUND;
                end else begin
                    rounded = ({1'b0, req.request_bytes} + TEMP_ROUND) & ~TEMP_ROUND;
                end
                need = {3'b0, bottom_lvl} + {3'b0, top_lvl} + {2'b0, rounded};
                if (need > {3'b0, arena_size}) begin
                    rsp.status = fatal_mode ? ST_FATAL : ST_SOFT;
                end else begin
                    if (req.op == OP_ALLOC_PERM) begin
                        rsp.block_offset = bottom_lvl;
                        bottom_lvl = bottom_lvl + rounded[ADDR_BITS-1:0];
                        if (perm_count != CNT_MAX) begin
                            perm_count = perm_count + 1'b1;
                        end
                    end else begin
                        top_lvl = top_lvl + rounded[ADDR_BITS-1:0];
                        rsp.block_offset = arena_size - top_lvl;
                    end
                    used = {1'b0, bottom_lvl} + {1'b0, top_lvl};
                    if (used > {1'b0, peak_lvl}) begin
                        peak_lvl = used[ADDR_BITS-1:0];
                    end
                end
            end
            OP_FREE_TEMP: begin
                top_lvl = '0;
            end
            OP_CLEAR: begin
                fatal_mode = 1'b1;
                perm_count = '0;
                peak_lvl = '0;
                bottom_lvl = '0;
                top_lvl = '0;
            end
            OP_SET_MODE: begin
                fatal_mode = req.fail_mode;
            end
            OP_MARK: begin
                mark_lvl = bottom_lvl;
                rsp.block_offset = bottom_lvl;
            end
            default: begin
            end
        endcase
        rsp.bottom_used = bottom_lvl;
        rsp.top_used = top_lvl;
        rsp.peak_used = peak_lvl;
        rsp.alloc_total = perm_count;
        rsp.since_mark = bottom_lvl - mark_lvl;
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_req word;
        t_rsp want;
        int   pushed;
        int   popped;
        pushed = 0;
        popped = 0;
        if (!i_rst_n) begin
            arena_size = ARENA_RESET;
            bottom_lvl = '0;
            top_lvl = '0;
            peak_lvl = '0;
            mark_lvl = '0;
            perm_count = '0;
            fatal_mode = 1'b1;
            predicted_rsp.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                arena_size = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (predicted_rsp.size() == 0) begin
                    $display("%0t: response word with no request waiting, status %0h offset %0h",
                             $time, i_status, i_block_offset);
                    o_fail_count++;
                end else begin
                    want = predicted_rsp.pop_front();
                    popped = 1;
                    o_result_count++;
                    if (want.status != ST_DONE) begin
                        o_refusal_count++;
                    end
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("block_offset", 32'(want.block_offset), 32'(i_block_offset));
                    check_field("bottom_used", 32'(want.bottom_used), 32'(i_bottom_used));
                    check_field("top_used", 32'(want.top_used), 32'(i_top_used));
                    check_field("peak_used", 32'(want.peak_used), 32'(i_peak_used));
                    check_field("alloc_total", 32'(want.alloc_total), 32'(i_alloc_total));
                    check_field("since_mark", 32'(want.since_mark), 32'(i_since_mark));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                word.op = i_op;
                word.request_bytes = i_request_bytes;
                word.fail_mode = i_fail_mode;
                predicted_rsp.push_back(arena_step(word));
                pushed = 1;
            end
            o_outstanding <= o_outstanding + pushed - popped;
        end
    end

endmodule

FILE: bench/tb_double_ended_arena_allocator_top.sv
// Testbench top for the arena allocator: clock, reset, stimulus, watchdog and verdict.
module tb_double_ended_arena_allocator_top;
    import dea_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_WORDS = 130;
    localparam int NUM_PHASES = 6;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [2:0]           i_op = '0;
    logic [ADDR_BITS-1:0] i_request_bytes = '0;
    logic                 i_fail_mode = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [ADDR_BITS-1:0] i_cfg_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_status;
    logic [ADDR_BITS-1:0] o_block_offset;
    logic [ADDR_BITS-1:0] o_bottom_used;
    logic [ADDR_BITS-1:0] o_top_used;
    logic [ADDR_BITS-1:0] o_peak_used;
    logic [CNT_BITS-1:0]  o_alloc_total;
    logic [ADDR_BITS-1:0] o_since_mark;
    logic                 o_cfg_ready;

    int fail_count;
    int outstanding;
    int result_count;
    int refusal_count;
    int words_sent = 0;
    int arena_writes = 0;
    int quiet_cycles = 0;
    int stall_run = 0;
    int in_gap_pct = 30;
    int out_stall_pct = 30;
    logic [ADDR_BITS-1:0] cur_arena = ARENA_RESET;

    double_ended_arena_allocator_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_request_bytes(i_request_bytes),
        .i_fail_mode    (i_fail_mode),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_block_offset (o_block_offset),
        .o_bottom_used  (o_bottom_used),
        .o_top_used     (o_top_used),
        .o_peak_used    (o_peak_used),
        .o_alloc_total  (o_alloc_total),
        .o_since_mark   (o_since_mark),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    arena_checker u_arena_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_request_bytes(i_request_bytes),
        .i_fail_mode    (i_fail_mode),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_block_offset (o_block_offset),
        .i_bottom_used  (o_bottom_used),
        .i_top_used     (o_top_used),
        .i_peak_used    (o_peak_used),
        .i_alloc_total  (o_alloc_total),
        .i_since_mark   (o_since_mark),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_result_count (result_count),
        .o_refusal_count(refusal_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99, 0) >= pct) begin
            return 0;
        end
        if ($urandom_range(9, 0) == 0) begin
            return $urandom_range(40, 8);
        end
        return $urandom_range(3, 1);
    endfunction

    always @(posedge i_clk) begin : out_stall_gen
        int n;
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            n = pick_gap(out_stall_pct);
            i_out_stall <= (n > 0);
            stall_run <= (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [ADDR_BITS-1:0] bytes,
                             input logic mode);
        int gap;
        gap = pick_gap(in_gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_request_bytes <= bytes;
        i_fail_mode <= mode;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_arena(input logic [ADDR_BITS-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_arena = value;
        arena_writes++;
    endtask

    task automatic random_word();
        int                   r;
        logic [2:0]           op;
        logic [ADDR_BITS-1:0] bytes;
        r = $urandom_range(99, 0);
        if (r < 40) begin
            op = OP_ALLOC_PERM;
        end else if (r < 72) begin
            op = OP_ALLOC_TEMP;
        end else if (r < 80) begin
            op = OP_FREE_TEMP;
        end else if (r < 84) begin
            op = OP_CLEAR;
        end else if (r < 89) begin
            op = OP_SET_MODE;
        end else if (r < 95) begin
            op = OP_MARK;
        end else begin
            op = $urandom_range(1, 0) ? OP_RSVD_6 : OP_RSVD_7;
        end
        r = $urandom_range(99, 0);
        if (r < 50) begin
            bytes = ADDR_BITS'($urandom_range(64, 0));
        end else if (r < 80) begin
            bytes = ADDR_BITS'($urandom_range(int'(cur_arena >> 3), 0));
        end else if (r < 92) begin
            bytes = ADDR_BITS'($urandom_range(int'(cur_arena), 0));
        end else begin
            bytes = ADDR_BITS'($urandom);
        end
        send_word(op, bytes, 1'($urandom_range(1, 0)));
    endtask

    initial begin
        logic [ADDR_BITS-1:0] phase_arena [NUM_PHASES];
        phase_arena[0] = 24'd4096;
        phase_arena[1] = 24'd0;
        phase_arena[2] = 24'hFF_FFFF;
        phase_arena[3] = 24'd1000;
        phase_arena[4] = ADDR_BITS'($urandom_range(65536, 64));
        phase_arena[5] = 24'd300;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_MARK, 24'h00_0000, 1'b0);
        send_word(OP_ALLOC_PERM, 24'h00_0000, 1'b0);
        send_word(OP_ALLOC_PERM, 24'h00_0001, 1'b1);
        send_word(OP_ALLOC_PERM, 24'h00_0020, 1'b0);
        send_word(OP_ALLOC_TEMP, 24'h00_0000, 1'b0);
        send_word(OP_ALLOC_TEMP, 24'h00_0001, 1'b0);
        send_word(OP_ALLOC_TEMP, 24'h00_0005, 1'b1);
        send_word(OP_ALLOC_PERM, 24'hFF_FFFF, 1'b1);
        send_word(OP_ALLOC_TEMP, 24'hFF_FFFF, 1'b0);
        send_word(OP_SET_MODE, 24'hFF_FFFF, 1'b0);
        send_word(OP_ALLOC_PERM, 24'hFF_FFFF, 1'b1);
        send_word(OP_MARK, 24'h12_3456, 1'b1);
        send_word(OP_ALLOC_PERM, 24'h00_0064, 1'b0);
        send_word(OP_FREE_TEMP, 24'hAB_CDEF, 1'b1);
        send_word(OP_RSVD_6, 24'h55_5555, 1'b1);
        send_word(OP_RSVD_7, 24'hAA_AAAA, 1'b0);
        send_word(OP_CLEAR, 24'h00_0000, 1'b0);
        send_word(OP_SET_MODE, 24'h00_0000, 1'b1);
        send_word(OP_SET_MODE, 24'h00_0000, 1'b0);
        send_word(OP_ALLOC_TEMP, ARENA_RESET, 1'b0);
        send_word(OP_ALLOC_PERM, 24'h00_0000, 1'b0);
        send_word(OP_ALLOC_TEMP, 24'h00_0000, 1'b0);
        send_word(OP_ALLOC_TEMP, 24'h00_0001, 1'b0);
        send_word(OP_FREE_TEMP, 24'h00_0000, 1'b0);
        send_word(OP_CLEAR, 24'h00_0000, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_arena(phase_arena[p]);
            if (p == 3) begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end else begin
                in_gap_pct = $urandom_range(50, 15);
                out_stall_pct = $urandom_range(50, 15);
            end
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (p == 1 && i == PHASE_WORDS / 2) begin
                    drain();
                end
                random_word();
            end
        end

        write_arena(ARENA_RESET);
        in_gap_pct = 30;
        out_stall_pct = 30;
        send_word(OP_CLEAR, 24'h00_0000, 1'b0);
        for (int i = 0; i < 40; i++) begin
            random_word();
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (outstanding != 0) begin
            $display("%0t: %0d expected response words never arrived", $time, outstanding);
        end
        $display("Covered %0d request words over %0d arena sizes with random gaps and stalls;",
                 words_sent, arena_writes);
        $display("%0d responses were checked, %0d of them refusals.",
                 result_count, refusal_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: double_ended_arena_allocator_top.f
rtl/core/dea_pkg.sv
rtl/core/dea_in_reg.sv
rtl/core/dea_engine.sv
rtl/core/dea_out_reg.sv
rtl/core/double_ended_arena_allocator_top.sv
bench/arena_checker.sv
bench/tb_double_ended_arena_allocator_top.sv
